// ===== rtl/lsl_pkg.sv =====
`default_nettype none

package lsl_pkg;

  // Command codes carried in the cmd field of an input item.
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_RAISE  = 3'd2;
  localparam logic [2:0] CMD_LOWER  = 3'd3;
  localparam logic [2:0] CMD_FIND   = 3'd4;

  // Status codes returned in the status field of a result item.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_PRESENT   = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] win_id;
    logic [7:0]  layer;
    logic        layer_aware;
  } lsl_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [3:0] moved;
    logic [4:0] length;
  } lsl_out_t;

  // What a cell does with its contents at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_LOAD
  } lsl_cell_op_t;

  // Per-cell compare results against the command being executed.
  typedef struct packed {
    logic match;  // stored identifier equals the command's identifier
    logic ge;     // command's layer is at or above the stored layer
    logic le;     // command's layer is at or below the stored layer
  } lsl_flags_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } lsl_state_t;

endpackage

`default_nettype wire

// ===== rtl/layered_stacking_list.sv =====
`default_nettype none

// Channel   Direction  Payload     Handshake
// in_       input      lsl_in_t    in_valid / in_stall
// out_      output     lsl_out_t   out_valid / out_stall
//
// Every item is first accepted into the command register and then executed: all
// cells compare against it in parallel and shift their contents.
// A new item is taken only once the previous one has executed.
// The execute cycle waits while the previous result is still stalled at the output.
// Reset empties the list and the result register; cell contents are not cleared.

module layered_stacking_list
  import lsl_pkg::*;
#(
  parameter int LIST_DEPTH = 16,
  parameter int ID_WIDTH   = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire lsl_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output lsl_out_t      out_data
);

  // Index width for a list position, and count width wide enough to hold the depth.
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  lsl_state_t          state_r, state_nxt;
  lsl_in_t             cmd_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  lsl_out_t            out_data_r, out_data_nxt;

  logic [ID_WIDTH-1:0] cmd_id;
  logic                fire;

  // The chain of cells. Each cell sees its neighbors' contents so that a whole
  // range of entries can slide up or down by one place at once.
  logic [ID_WIDTH-1:0] cell_id    [LIST_DEPTH];
  logic [7:0]          cell_layer [LIST_DEPTH];
  lsl_flags_t          cell_flags [LIST_DEPTH];
  lsl_cell_op_t        cell_op    [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] valid_vec;
  logic [LIST_DEPTH-1:0] match_vec;

  assign cmd_id = ID_WIDTH'(cmd_r.win_id);

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [ID_WIDTH-1:0] prev_id, next_id;
    logic [7:0]          prev_layer, next_layer;

    if (g == 0) begin : g_top
      assign prev_id    = '0;
      assign prev_layer = '0;
    end else begin : g_mid_prev
      assign prev_id    = cell_id[g-1];
      assign prev_layer = cell_layer[g-1];
    end

    if (g == LIST_DEPTH - 1) begin : g_bottom
      assign next_id    = '0;
      assign next_layer = '0;
    end else begin : g_mid_next
      assign next_id    = cell_id[g+1];
      assign next_layer = cell_layer[g+1];
    end

    lsl_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op[g]),
      .cmp_id     (cmd_id),
      .cmp_layer  (cmd_r.layer),
      .prev_id    (prev_id),
      .prev_layer (prev_layer),
      .next_id    (next_id),
      .next_layer (next_layer),
      .id         (cell_id[g]),
      .layer      (cell_layer[g]),
      .flags      (cell_flags[g])
    );

    // An entry is live when its position lies below the current count.
    assign valid_vec[g] = (CW'(g) < count_r);
    assign match_vec[g] = valid_vec[g] & cell_flags[g].match;
  end

  // Search results over the live entries: where the identifier sits, the topmost
  // entry the mover may sit above, and the bottommost entry it may sit below.
  logic          found;
  logic [IW-1:0] found_idx;
  logic          have_ge, have_le;
  logic [IW-1:0] ge_idx, le_idx;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    have_ge   = 1'b0;
    ge_idx    = '0;
    have_le   = 1'b0;
    le_idx    = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (match_vec[k]) begin
        found     = 1'b1;
        found_idx = found_idx | IW'(k);
      end
    end
    for (int k = LIST_DEPTH - 1; k >= 0; k--) begin
      if (valid_vec[k] && cell_flags[k].ge) begin
        have_ge = 1'b1;
        ge_idx  = IW'(k);
      end
    end
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (valid_vec[k] && cell_flags[k].le) begin
        have_le = 1'b1;
        le_idx  = IW'(k);
      end
    end
  end

  // Destination of a raise or lower. In layer-aware mode a raise stops at the
  // first entry whose layer is not above the mover's, a lower at the last entry
  // whose layer is not below it; otherwise a raise goes to the top, a lower to the bottom.
  logic          list_full;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] raise_dst, lower_dst, dst_idx;

  assign list_full = (count_r == CW'(LIST_DEPTH));
  assign last_idx  = IW'(count_r - CW'(1));

  always_comb begin
    if (!cmd_r.layer_aware) begin
      raise_dst = '0;
      lower_dst = last_idx;
    end else begin
      raise_dst = (have_ge && (ge_idx < found_idx)) ? ge_idx : found_idx;
      lower_dst = (have_le && (le_idx > found_idx)) ? le_idx : found_idx;
    end
    dst_idx = (cmd_r.cmd == CMD_RAISE) ? raise_dst : lower_dst;
  end

  // The execute cycle goes ahead only when the result register is free.
  assign fire = (state_r == ST_EXEC) && !(out_valid_r && out_stall);

  // Command decode: result fields, new count and the operation of every cell.
  always_comb begin
    out_data_nxt          = out_data_r;
    count_nxt             = count_r;
    out_data_nxt.status   = STAT_OK;
    out_data_nxt.position = '0;
    out_data_nxt.moved    = '0;

    case (cmd_r.cmd)
      CMD_ADD: begin
        if (found) begin
          out_data_nxt.status   = STAT_PRESENT;
          out_data_nxt.position = 4'(found_idx);
        end else if (list_full) begin
          out_data_nxt.status = STAT_FULL;
        end else begin
          out_data_nxt.position = 4'(count_r);
          count_nxt             = count_r + CW'(1);
        end
      end
      CMD_DELETE, CMD_FIND: begin
        if (found) begin
          out_data_nxt.position = 4'(found_idx);
          if (cmd_r.cmd == CMD_DELETE) begin
            count_nxt = count_r - CW'(1);
          end
        end else begin
          out_data_nxt.status = STAT_NOT_FOUND;
        end
      end
      CMD_RAISE: begin
        if (found) begin
          out_data_nxt.position = 4'(dst_idx);
          out_data_nxt.moved    = 4'(found_idx - dst_idx);
        end else begin
          out_data_nxt.status = STAT_NOT_FOUND;
        end
      end
      CMD_LOWER: begin
        if (found) begin
          out_data_nxt.position = 4'(dst_idx);
          out_data_nxt.moved    = 4'(dst_idx - found_idx);
        end else begin
          out_data_nxt.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        // Unknown commands leave the list alone and report success.
      end
    endcase
    out_data_nxt.length = 5'(count_nxt);

    for (int k = 0; k < LIST_DEPTH; k++) begin
      cell_op[k] = CELL_HOLD;
      if (fire) begin
        case (cmd_r.cmd)
          CMD_ADD: begin
            if (!found && !list_full && (CW'(k) == count_r)) begin
              cell_op[k] = CELL_LOAD;
            end
          end
          CMD_DELETE: begin
            if (found && (IW'(k) >= found_idx)) begin
              cell_op[k] = CELL_FROM_NEXT;
            end
          end
          CMD_RAISE: begin
            if (found && (IW'(k) == dst_idx)) begin
              cell_op[k] = CELL_LOAD;
            end else if (found && (IW'(k) > dst_idx) && (IW'(k) <= found_idx)) begin
              cell_op[k] = CELL_FROM_PREV;
            end
          end
          CMD_LOWER: begin
            if (found && (IW'(k) == dst_idx)) begin
              cell_op[k] = CELL_LOAD;
            end else if (found && (IW'(k) >= found_idx) && (IW'(k) < dst_idx)) begin
              cell_op[k] = CELL_FROM_NEXT;
            end
          end
          default: begin
            cell_op[k] = CELL_HOLD;
          end
        endcase
      end
    end
  end

  // Sequencer: idle takes an item, execute applies it once the output is free.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      cmd_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never runs past the number of cells.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("entry count exceeds list depth");

  // Identifiers stay unique, so at most one live cell matches.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(match_vec))
    else $error("identifier held by more than one entry");

  // An accepted item is always followed by its execute cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted item not executed");

  // A result only appears right after an execute cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result produced without a command");

  // The count changes only when a command executes.
  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(fire) && $past(rst_n) |-> $stable(count_r))
    else $error("count changed outside execute");

endmodule

`default_nettype wire

// ===== rtl/lsl_cell.sv =====
`default_nettype none

module lsl_cell
  import lsl_pkg::*;
#(
  parameter int ID_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire lsl_cell_op_t        op,
  input  wire logic [ID_WIDTH-1:0] cmp_id,
  input  wire logic [7:0]          cmp_layer,
  input  wire logic [ID_WIDTH-1:0] prev_id,
  input  wire logic [7:0]          prev_layer,
  input  wire logic [ID_WIDTH-1:0] next_id,
  input  wire logic [7:0]          next_layer,
  output logic [ID_WIDTH-1:0]      id,
  output logic [7:0]               layer,
  output lsl_flags_t               flags
);

  logic [ID_WIDTH-1:0] id_r;
  logic [7:0]          layer_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_FROM_PREV: begin
        id_r    <= prev_id;
        layer_r <= prev_layer;
      end
      CELL_FROM_NEXT: begin
        id_r    <= next_id;
        layer_r <= next_layer;
      end
      CELL_LOAD: begin
        id_r    <= cmp_id;
        layer_r <= cmp_layer;
      end
      default: begin
        id_r    <= id_r;
        layer_r <= layer_r;
      end
    endcase
  end

  always_comb begin
    flags.match = (id_r == cmp_id);
    flags.ge    = (cmp_layer >= layer_r);
    flags.le    = (cmp_layer <= layer_r);
  end

  assign id    = id_r;
  assign layer = layer_r;

endmodule

`default_nettype wire
